>>> hw/rtl/nv12_pkg.sv
// ----------------------------------------------------------------------------
// NV12 to RGB565 package
// Register map, reset values and conversion coefficients of the converter;
// the register map is also used by its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nv12_pkg;

  localparam int CfgW  = 11;
  localparam int ProdW = 18;
  localparam int SumW  = 19;

  localparam logic [CfgW-1:0] WidthReset  = 11'd640;
  localparam logic [CfgW-1:0] HeightReset = 11'd480;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  localparam logic signed [ProdW-1:0] CoefRV = 18'sd359;
  localparam logic signed [ProdW-1:0] CoefGU = 18'sd88;
  localparam logic signed [ProdW-1:0] CoefGV = 18'sd183;
  localparam logic signed [ProdW-1:0] CoefBU = 18'sd454;
  localparam logic signed [8:0]       ChromaOffset = 9'sd128;

  // Floor of x/256, clamped to 0..255.
  function automatic logic [7:0] clamp_shift(input logic signed [SumW-1:0] x);
    logic [7:0] res;
    if (x[SumW-1]) begin
      res = 8'd0;
    end else if (|x[SumW-2:16]) begin
      res = 8'd255;
    end else begin
      res = x[15:8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nv12_ram.sv
// ----------------------------------------------------------------------------
// NV12 generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nv12_ram #(
  parameter int Width = 16,
  parameter int Depth = 512,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AddrW-1:0]        waddr_i,
  input  wire logic [Width-1:0]        wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AddrW-1:0]        raddr_i,
  output logic      [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/nv12_to_rgb565_converter_top.sv
// ----------------------------------------------------------------------------
// NV12 to RGB565 converter
// Converts a raster stream of semi-planar 4:2:0 pixels to packed RGB565.
// ----------------------------------------------------------------------------
// The slave stream takes one pixel per word: luma, and on even lines at even
// columns the Cb/Cr pair of that column pair. The master stream returns one
// RGB565 word per pixel, with tlast on the last pixel of a line and tuser on
// the last pixel of the frame. The user must write image width and height
// through the APB port only while the stream is idle, which the block does
// not enforce. Odd values round down to even and are kept within 2 and the
// maximum size. Throughput is one word per cycle while the receiver does
// not stall. The accepting edge starts the chroma line memory read; the
// coefficient multiplies are then registered, and after them the sums,
// clamps and packing.
// Even lines write the chroma pair into the line memory, odd lines read it
// back; the memory needs no clearing pass and no valid bits.
// Reset clears the pixel and line position, the held chroma pair, the
// geometry registers (640 by 480) and all pipeline valid flags.
// When the receiver stalls, the result waits in the output register and the
// pipeline still takes new pixels until every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module nv12_to_rgb565_converter_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // luma[7:0], chroma_blue[15:8], chroma_red[23:16]
  // Master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // rgb565[15:0]
  output logic             m_axis_tlast,
  output logic             m_axis_tuser,   // frame_end[0]
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CfgW   = nv12_pkg::CfgW;
  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int LineW  = $clog2(MAX_HEIGHT);
  localparam int AddrW  = (ColW > 1) ? ColW - 1 : 1;
  localparam int Depth  = MAX_WIDTH / 2;
  localparam int DimA   = (ColW >= LineW) ? ColW + 1 : LineW + 1;
  localparam int DimW   = (DimA > CfgW) ? DimA : CfgW;
  localparam logic [DimW-1:0] MaxWEven = DimW'(MAX_WIDTH - MAX_WIDTH % 2);
  localparam logic [DimW-1:0] MaxHEven = DimW'(MAX_HEIGHT - MAX_HEIGHT % 2);
  localparam logic [DimW-1:0] MinDim   = DimW'(2);

  // Configuration registers
  logic [CfgW-1:0] width_q, height_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= nv12_pkg::WidthReset;
      height_q <= nv12_pkg::HeightReset;
    end else if (cfg_wr) begin
      if (paddr[2] == nv12_pkg::REG_WIDTH) begin
        width_q <= pwdata[CfgW-1:0];
      end else begin
        height_q <= pwdata[CfgW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == nv12_pkg::REG_WIDTH) begin
      prdata = 32'(width_q);
    end else begin
      prdata = 32'(height_q);
    end
  end

  // Geometry
  logic [DimW-1:0] w_even, h_even, w_fit, h_fit, w_last, h_last;

  always_comb begin
    w_even = DimW'({width_q[CfgW-1:1], 1'b0});
    h_even = DimW'({height_q[CfgW-1:1], 1'b0});
    if (w_even < MinDim) begin
      w_fit = MinDim;
    end else if (w_even > MaxWEven) begin
      w_fit = MaxWEven;
    end else begin
      w_fit = w_even;
    end
    if (h_even < MinDim) begin
      h_fit = MinDim;
    end else if (h_even > MaxHEven) begin
      h_fit = MaxHEven;
    end else begin
      h_fit = h_even;
    end
    w_last = w_fit - DimW'(1);
    h_last = h_fit - DimW'(1);
  end

  // Stage 0: position tracking and chroma line memory access
  logic              rdy1, rdy2, rdy3;
  logic              in_acc;
  logic [ColW-1:0]   col_q, col_d;
  logic [LineW-1:0]  line_q, line_d;
  logic [15:0]       held_q, held_d;
  logic [7:0]        luma_in;
  logic [15:0]       chroma_in, chroma0;
  logic              odd_line, even_col, lend0, fend0;
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  pair_addr;
  logic [15:0]       ram_rdata;

  assign s_axis_tready = rdy1;
  assign in_acc    = s_axis_tvalid & rdy1;
  assign luma_in   = s_axis_tdata[7:0];
  assign chroma_in = {s_axis_tdata[15:8], s_axis_tdata[23:16]};
  assign odd_line  = line_q[0];
  assign even_col  = ~col_q[0];
  assign lend0     = DimW'(col_q) >= w_last;
  assign fend0     = lend0 & (DimW'(line_q) >= h_last);
  assign pair_addr = AddrW'(col_q >> 1);
  assign ram_we    = in_acc & ~odd_line & even_col;
  assign ram_re    = in_acc & odd_line;
  assign chroma0   = even_col ? chroma_in : held_q;

  always_comb begin
    held_d = ram_we ? chroma_in : held_q;
    col_d  = col_q;
    line_d = line_q;
    if (in_acc) begin
      if (lend0) begin
        col_d  = '0;
        line_d = fend0 ? '0 : line_q + LineW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
      held_q <= '0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
      held_q <= held_d;
    end
  end

  nv12_ram #(
    .Width (16),
    .Depth (Depth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pair_addr),
    .wdata_i (chroma_in),
    .re_i    (ram_re),
    .raddr_i (pair_addr),
    .rdata_o (ram_rdata)
  );

  // Stage 1: chroma select and multiplies
  logic        v1_q, odd1_q, lend1_q, fend1_q;
  logic [7:0]  luma1_q;
  logic [15:0] chroma1_q, chroma_sel;
  logic signed [8:0] u_s, v_s;
  logic signed [nv12_pkg::ProdW-1:0] prod_rv_d, prod_gu_d, prod_gv_d, prod_bu_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      luma1_q   <= luma_in;
      odd1_q    <= odd_line;
      chroma1_q <= chroma0;
      lend1_q   <= lend0;
      fend1_q   <= fend0;
    end
  end

  assign chroma_sel = odd1_q ? ram_rdata : chroma1_q;
  assign u_s = $signed({1'b0, chroma_sel[15:8]}) - nv12_pkg::ChromaOffset;
  assign v_s = $signed({1'b0, chroma_sel[7:0]}) - nv12_pkg::ChromaOffset;
  assign prod_rv_d = nv12_pkg::ProdW'(v_s) * nv12_pkg::CoefRV;
  assign prod_gu_d = nv12_pkg::ProdW'(u_s) * nv12_pkg::CoefGU;
  assign prod_gv_d = nv12_pkg::ProdW'(v_s) * nv12_pkg::CoefGV;
  assign prod_bu_d = nv12_pkg::ProdW'(u_s) * nv12_pkg::CoefBU;

  // Stage 2: sums, clamps and packing
  logic        v2_q, lend2_q, fend2_q;
  logic [7:0]  luma2_q;
  logic signed [nv12_pkg::ProdW-1:0] prod_rv_q, prod_gu_q, prod_gv_q, prod_bu_q;
  logic signed [nv12_pkg::SumW-1:0]  yy, sum_r, sum_g, sum_b;
  logic [7:0]  r8, g8, b8;
  logic [15:0] rgb_d;

  assign rdy2 = ~v2_q | rdy3;
  assign rdy1 = ~v1_q | rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      luma2_q   <= luma1_q;
      lend2_q   <= lend1_q;
      fend2_q   <= fend1_q;
      prod_rv_q <= prod_rv_d;
      prod_gu_q <= prod_gu_d;
      prod_gv_q <= prod_gv_d;
      prod_bu_q <= prod_bu_d;
    end
  end

  assign yy    = $signed({3'b000, luma2_q, 8'h00});
  assign sum_r = yy + nv12_pkg::SumW'(prod_rv_q);
  assign sum_g = yy - nv12_pkg::SumW'(prod_gu_q) - nv12_pkg::SumW'(prod_gv_q);
  assign sum_b = yy + nv12_pkg::SumW'(prod_bu_q);
  assign r8    = nv12_pkg::clamp_shift(sum_r);
  assign g8    = nv12_pkg::clamp_shift(sum_g);
  assign b8    = nv12_pkg::clamp_shift(sum_b);
  assign rgb_d = {r8[7:3], g8[7:2], b8[7:3]};

  // Stage 3: output register
  logic        v3_q, lend3_q, fend3_q;
  logic [15:0] rgb_q;

  assign rdy3 = ~v3_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      rgb_q   <= rgb_d;
      lend3_q <= lend2_q;
      fend3_q <= fend2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = rgb_q;
  assign m_axis_tlast  = lend3_q;
  assign m_axis_tuser  = fend3_q;

endmodule

`default_nettype wire

>>> hw/rtl/nv12_checker.sv
// ----------------------------------------------------------------------------
// NV12 converter checker
// Port-level assertions on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module nv12_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("Stalled output word changed.");

  a_frame_on_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("Frame end without line end.");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input stalled while output register is empty.");

  a_cfg_readback : assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == nv12_pkg::REG_WIDTH) |=>
      !(psel && !pwrite && (paddr[2] == nv12_pkg::REG_WIDTH)) ||
      (prdata[10:0] == $past(pwdata[10:0])))
    else $error("Width register readback differs from the last write.");

endmodule

bind nv12_to_rgb565_converter_top nv12_checker u_nv12_checker (.*);

`default_nettype wire
